/* rtl/dpie_pkg.sv */
// ----------------------------------------------------------------------------
// dpie_pkg
// Shared types and constants for the double integer power unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpie_pkg;

  localparam int unsigned ExponentWidthDefault = 32;

  localparam logic [63:0] OneBits   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] CanonNan  = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] InfMag    = 63'h7FF0_0000_0000_0000;

  // internal exponent, biased, signed
  localparam int unsigned ExpW = 14;

  typedef enum logic {
    OP_MUL,
    OP_RECIP
  } fpu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_ACC,
    S_SQ,
    S_DIV
  } seq_state_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_PRENORM,
    F_DIV,
    F_NORM,
    F_DENORM,
    F_ROUND,
    F_DONE
  } fpu_state_e;

  typedef struct packed {
    logic    start;
    fpu_op_e op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

endpackage

`default_nettype wire

/* rtl/dpie_fpu.sv */
// ----------------------------------------------------------------------------
// dpie_fpu
// Multicycle binary64 multiply and reciprocal, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module dpie_fpu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dpie_pkg::fpu_req_t req_i,
  input  wire logic [63:0]       a_i,
  input  wire logic [63:0]       b_i,
  output      dpie_pkg::fpu_rsp_t rsp_o
);

  localparam int unsigned EW = dpie_pkg::ExpW;

  dpie_pkg::fpu_state_e state_q, state_d;
  logic                 sign_q, sign_d;
  logic signed [EW-1:0] er_q, er_d;
  logic [105:0]         p_q, p_d;
  logic [52:0]          ma_q, ma_d, mb_q, mb_d;
  logic [53:0]          pp_q, pp_d;
  logic [53:0]          rem_q, rem_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [63:0]          res_q, res_d;

  // operand classification
  logic a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [EW-1:0] ea, eb;
  logic [26:0]   mul_x, mul_y;
  logic [105:0]  pp_ext;
  logic [53:0]   sum;
  logic          rnd_inc;
  logic signed [EW-1:0] ef;
  logic [51:0]   frac;
  logic          ge;
  logic [53:0]   rem_sub;

  always_comb begin
    a_zero = (a_i[62:0] == 63'd0);
    b_zero = (b_i[62:0] == 63'd0);
    a_inf  = (a_i[62:0] == dpie_pkg::InfMag);
    b_inf  = (b_i[62:0] == dpie_pkg::InfMag);
    a_nan  = (a_i[62:0] > dpie_pkg::InfMag);
    b_nan  = (b_i[62:0] > dpie_pkg::InfMag);
    ea = {{(EW-11){1'b0}}, (a_i[62:52] == 11'd0) ? 11'd1 : a_i[62:52]};
    eb = {{(EW-11){1'b0}}, (b_i[62:52] == 11'd0) ? 11'd1 : b_i[62:52]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpie_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    er_q   <= er_d;
    p_q    <= p_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    pp_q   <= pp_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    er_d    = er_q;
    p_d     = p_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    pp_d    = pp_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;

    // partial product operands, 27x27 split
    case (cnt_q[1:0])
      2'd0:    begin mul_x = ma_q[26:0];          mul_y = mb_q[26:0];          end
      2'd1:    begin mul_x = ma_q[26:0];          mul_y = {1'b0, mb_q[52:27]}; end
      2'd2:    begin mul_x = {1'b0, ma_q[52:27]}; mul_y = mb_q[26:0];          end
      default: begin mul_x = {1'b0, ma_q[52:27]}; mul_y = {1'b0, mb_q[52:27]}; end
    endcase
    case (cnt_q[2:0])
      3'd1:    pp_ext = {52'd0, pp_q};
      3'd2,
      3'd3:    pp_ext = {52'd0, pp_q} << 27;
      default: pp_ext = {52'd0, pp_q} << 54;
    endcase

    ge      = (rem_q >= {1'b0, ma_q});
    rem_sub = ge ? (rem_q - {1'b0, ma_q}) : rem_q;

    rnd_inc = p_q[52] & ((|p_q[51:0]) | p_q[53]);
    sum     = {1'b0, p_q[105:53]} + {53'd0, rnd_inc};
    if (sum[53]) begin
      ef   = er_q + EW'(1);
      frac = 52'd0;
    end else if (sum[52]) begin
      ef   = er_q;
      frac = sum[51:0];
    end else begin
      ef   = '0;
      frac = sum[51:0];
    end

    case (state_q)
      dpie_pkg::F_IDLE: begin
        if (req_i.start) begin
          cnt_d = '0;
          p_d   = '0;
          if (req_i.op == dpie_pkg::OP_MUL) begin
            sign_d = a_i[63] ^ b_i[63];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
              res_d   = dpie_pkg::CanonNan;
              state_d = dpie_pkg::F_DONE;
            end else if (a_inf || b_inf) begin
              res_d   = {a_i[63] ^ b_i[63], dpie_pkg::InfMag};
              state_d = dpie_pkg::F_DONE;
            end else if (a_zero || b_zero) begin
              res_d   = {a_i[63] ^ b_i[63], 63'd0};
              state_d = dpie_pkg::F_DONE;
            end else begin
              ma_d    = {a_i[62:52] != 11'd0, a_i[51:0]};
              mb_d    = {b_i[62:52] != 11'd0, b_i[51:0]};
              er_d    = ea + eb - EW'(1022);
              state_d = dpie_pkg::F_MUL;
            end
          end else begin
            sign_d = a_i[63];
            if (a_nan) begin
              res_d   = dpie_pkg::CanonNan;
              state_d = dpie_pkg::F_DONE;
            end else if (a_inf) begin
              res_d   = {a_i[63], 63'd0};
              state_d = dpie_pkg::F_DONE;
            end else if (a_zero) begin
              res_d   = {a_i[63], dpie_pkg::InfMag};
              state_d = dpie_pkg::F_DONE;
            end else begin
              ma_d    = {a_i[62:52] != 11'd0, a_i[51:0]};
              er_d    = EW'(2046) - ea;
              state_d = dpie_pkg::F_PRENORM;
            end
          end
        end
      end
      dpie_pkg::F_MUL: begin
        if (cnt_q < 6'd4) begin
          pp_d = mul_x * mul_y;
        end
        if (cnt_q != 6'd0) begin
          p_d = p_q + pp_ext;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd4) begin
          state_d = dpie_pkg::F_NORM;
        end
      end
      dpie_pkg::F_PRENORM: begin
        // subnormal divisor: bring the leading one up
        if (!ma_q[52]) begin
          ma_d = {ma_q[51:0], 1'b0};
          er_d = er_q + EW'(1);
        end else begin
          rem_d   = 54'd1 << 52;
          state_d = dpie_pkg::F_DIV;
        end
      end
      dpie_pkg::F_DIV: begin
        if (cnt_q < 6'd55) begin
          p_d   = {p_q[104:0], ge};
          rem_d = {rem_sub[52:0], 1'b0};
          cnt_d = cnt_q + 6'd1;
        end else begin
          p_d     = {p_q[54:0], rem_q != 54'd0, 50'd0};
          state_d = dpie_pkg::F_NORM;
        end
      end
      dpie_pkg::F_NORM: begin
        if (!p_q[105]) begin
          p_d  = {p_q[104:0], 1'b0};
          er_d = er_q - EW'(1);
        end else begin
          state_d = dpie_pkg::F_DENORM;
        end
      end
      dpie_pkg::F_DENORM: begin
        if (er_q < EW'(1)) begin
          if (er_q < -EW'(60)) begin
            // far below the smallest subnormal, only sticky is left
            p_d  = {105'd0, 1'b1};
            er_d = EW'(1);
          end else begin
            p_d  = {1'b0, p_q[105:2], p_q[1] | p_q[0]};
            er_d = er_q + EW'(1);
          end
        end else begin
          state_d = dpie_pkg::F_ROUND;
        end
      end
      dpie_pkg::F_ROUND: begin
        if (ef >= EW'(2047)) begin
          res_d = {sign_q, dpie_pkg::InfMag};
        end else begin
          res_d = {sign_q, ef[10:0], frac};
        end
        state_d = dpie_pkg::F_DONE;
      end
      dpie_pkg::F_DONE: begin
        state_d = dpie_pkg::F_IDLE;
      end
      default: begin
        state_d = dpie_pkg::F_IDLE;
      end
    endcase
  end

  assign rsp_o.done = (state_q == dpie_pkg::F_DONE);
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

/* rtl/double_pow_integer_exponent_unit.sv */
// operation: up to 2*EXPONENT_WIDTH-3 double multiplies, each summed from 27x27 partial
// products, plus a final reciprocal when the exponent is negative; subnormal values add
// normalisation shift steps to an operation; the receiver cannot stall
// throughput: one request at a time, busy stays high until the one-cycle result strobe
// reset: asynchronous active low, clears the sequencer and arithmetic unit states
// ----------------------------------------------------------------------------
// double_pow_integer_exponent_unit
// Double base raised to a signed integer power by square-and-multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module double_pow_integer_exponent_unit #(
  parameter int unsigned EXPONENT_WIDTH = dpie_pkg::ExponentWidthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [63:0]                      base_bits_i,
  input  wire logic signed [EXPONENT_WIDTH-1:0] exponent_i,
  output      logic                             power_valid_o,
  output      logic [63:0]                      power_bits_o
);

  dpie_pkg::seq_state_e      state_q, state_d;
  logic [EXPONENT_WIDTH-1:0] mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic [63:0]               acc_q, acc_d, sq_q, sq_d;
  logic                      valid_q, valid_d;
  logic [63:0]               out_q, out_d;
  logic [EXPONENT_WIDTH-1:0] exp_u;

  dpie_pkg::fpu_req_t req;
  dpie_pkg::fpu_rsp_t rsp;
  logic [63:0]        op_a, op_b;

  dpie_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .rsp_o  (rsp)
  );

  assign exp_u = exponent_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpie_pkg::S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    out_d     = out_q;
    valid_d   = 1'b0;
    req.start = 1'b0;
    req.op    = dpie_pkg::OP_MUL;
    op_a      = acc_q;
    op_b      = sq_q;

    case (state_q)
      dpie_pkg::S_IDLE: begin
        if (start) begin
          neg_d   = exp_u[EXPONENT_WIDTH-1];
          mag_d   = exp_u[EXPONENT_WIDTH-1] ? (~exp_u + 1'b1) : exp_u;
          acc_d   = dpie_pkg::OneBits;
          sq_d    = base_bits_i;
          state_d = dpie_pkg::S_STEP;
        end
      end
      dpie_pkg::S_STEP: begin
        if (mag_q == '0) begin
          if (!neg_q) begin
            out_d   = (acc_q[62:0] > dpie_pkg::InfMag) ? dpie_pkg::CanonNan : acc_q;
            valid_d = 1'b1;
            state_d = dpie_pkg::S_IDLE;
          end else begin
            // reciprocal handles zero, infinity and nan operands itself
            req.start = 1'b1;
            req.op    = dpie_pkg::OP_RECIP;
            state_d   = dpie_pkg::S_DIV;
          end
        end else if (mag_q[0]) begin
          req.start = 1'b1;
          state_d   = dpie_pkg::S_ACC;
        end else begin
          req.start = 1'b1;
          op_a      = sq_q;
          state_d   = dpie_pkg::S_SQ;
        end
      end
      dpie_pkg::S_ACC: begin
        if (rsp.done) begin
          acc_d   = rsp.res;
          mag_d   = {mag_q[EXPONENT_WIDTH-1:1], 1'b0};
          state_d = dpie_pkg::S_STEP;
        end
      end
      dpie_pkg::S_SQ: begin
        if (rsp.done) begin
          sq_d    = rsp.res;
          mag_d   = {1'b0, mag_q[EXPONENT_WIDTH-1:1]};
          state_d = dpie_pkg::S_STEP;
        end
      end
      dpie_pkg::S_DIV: begin
        if (rsp.done) begin
          out_d   = (rsp.res[62:0] > dpie_pkg::InfMag) ? dpie_pkg::CanonNan : rsp.res;
          valid_d = 1'b1;
          state_d = dpie_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dpie_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_q != dpie_pkg::S_IDLE);
  assign power_valid_o = valid_q;
  assign power_bits_o  = out_q;

endmodule

`default_nettype wire

/* rtl/dpie_checker.sv */
// ----------------------------------------------------------------------------
// dpie_checker
// Port level checks on the request and result timing of the power unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dpie_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic power_valid_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but unit not busy");

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_valid_o |-> $past(busy))
    else $error("result without a request in flight");

  a_fall_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> power_valid_o)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_valid_o |=> !power_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind double_pow_integer_exponent_unit dpie_checker u_dpie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .power_valid_o (power_valid_o)
);

`default_nettype wire

/* tb/double_pow_integer_exponent_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_pow_integer_exponent_checker
// Watches the request and result channels of the integer power unit, works
// out each expected power with host double arithmetic and compares results
// in order.
// ----------------------------------------------------------------------------
module double_pow_integer_exponent_checker #(
  parameter int unsigned EXPONENT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [63:0]                      base_bits_i,
  input  logic signed [EXPONENT_WIDTH-1:0] exponent_i,
  input  logic                             power_valid_i,
  input  logic [63:0]                      power_bits_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  logic [63:0] expected_powers[$];

  function automatic bit is_nan(logic [63:0] b);
    return (b & ~SignBit) > {1'b0, dpie_pkg::InfMag};
  endfunction

  // square-and-multiply, then reciprocal for negative powers
  function automatic logic [63:0] power_of(logic [63:0] b,
                                           logic signed [EXPONENT_WIDTH-1:0] e);
    real acc;
    real sq;
    logic [EXPONENT_WIDTH:0] mag;
    logic [63:0] pb;
    logic [63:0] res;
    acc = 1.0;
    sq = $bitstoreal(b);
    mag = e[EXPONENT_WIDTH-1] ? -{e[EXPONENT_WIDTH-1], e} : {1'b0, e};
    while (mag != '0) begin
      if (mag[0]) acc = acc * sq;
      sq = sq * sq;
      mag = mag >> 1;
    end
    pb = $realtobits(acc);
    if (!e[EXPONENT_WIDTH-1]) begin
      res = pb;
    end else if ((pb & ~SignBit) == '0) begin
      res = (pb & SignBit) | {1'b0, dpie_pkg::InfMag};
    end else if (is_nan(pb)) begin
      res = dpie_pkg::CanonNan;
    end else begin
      res = $realtobits(1.0 / acc);
    end
    if (is_nan(res)) res = dpie_pkg::CanonNan;
    return res;
  endfunction

  assign pending_o = expected_powers.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (power_valid_i) begin
        if (expected_powers.size() == 0) begin
          $error("power_bits: unexpected result %h", power_bits_i);
          fail_count_o <= fail_count_o + 1;
        end else if (expected_powers[0] !== power_bits_i) begin
          $error("power_bits: expected %h actual %h", expected_powers[0], power_bits_i);
          fail_count_o <= fail_count_o + 1;
          void'(expected_powers.pop_front());
        end else begin
          void'(expected_powers.pop_front());
        end
      end
      if (start_i && !busy_i)
        expected_powers.push_back(power_of(base_bits_i, exponent_i));
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed corner requests and about a thousand random base/exponent
// pairs into the integer power unit with random gaps; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned EW = 32;
  localparam int unsigned NumRandom = 1000;
  localparam int unsigned WatchdogLimit = 100000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [63:0]          base_bits_i = '0;
  logic signed [EW-1:0] exponent_i = '0;
  logic                 power_valid_o;
  logic [63:0]          power_bits_o;
  int                   fail_count;
  int                   pending;
  int                   quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  double_pow_integer_exponent_unit #(.EXPONENT_WIDTH(EW)) dut (
    .clk_i, .rst_ni, .start, .busy, .base_bits_i, .exponent_i,
    .power_valid_o, .power_bits_o
  );

  double_pow_integer_exponent_checker #(.EXPONENT_WIDTH(EW)) checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .base_bits_i, .exponent_i,
    .power_valid_i(power_valid_o), .power_bits_i(power_bits_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || power_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // holds the request until the unit takes it
  task automatic send_request(logic [63:0] b, logic signed [EW-1:0] e);
    start <= 1'b1;
    base_bits_i <= b;
    exponent_i <= e;
    do @(posedge clk_i); while (busy);
  endtask

  // the gap starts once the unit is idle so that it shows on the request side
  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy);
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1, 2: b[62:52] = 11'h3F0 + 11'($urandom_range(0, 30));
      3: b[62:52] = 11'($urandom_range(0, 1)) * 11'h7FF;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic signed [EW-1:0] random_exponent();
    case ($urandom_range(0, 3))
      0, 1: return EW'($signed($urandom_range(0, 80)) - 40);
      2: return EW'($signed($urandom_range(0, 4000)) - 2000);
      default: return EW'($urandom);
    endcase
  endfunction

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(64'h7FF4_0000_0000_0001, 0);
    send_request(64'h4000_0000_0000_0000, 1);
    send_request(64'h4000_0000_0000_0000, -1);
    send_request(64'h4000_0000_0000_0000, 32'sh7FFF_FFFF);
    send_request(64'h3FF0_0000_0000_0000, 32'sh8000_0000);
    send_request(64'hBFF0_0000_0000_0000, 32'sh7FFF_FFFF);
    send_request(64'hBFF0_0000_0000_0000, 32'sh8000_0000);
    send_request(64'h0000_0000_0000_0000, -3);
    send_request(64'h8000_0000_0000_0000, -3);
    send_request(64'h8000_0000_0000_0000, 3);
    send_request(64'h7FF0_0000_0000_0000, -2);
    send_request(64'hFFF0_0000_0000_0000, 3);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 3);
    send_request(64'h0000_0000_0000_0001, 1);
    send_request(64'h0000_0000_0000_0001, -1);
    send_request(64'h000F_FFFF_FFFF_FFFF, 2);
    send_request(64'h3FF0_0000_0000_0001, 32'sh7FFF_FFFF);
    send_request(64'h3FEF_FFFF_FFFF_FFFF, 32'sh8000_0000);
    send_request(64'h7FEF_FFFF_FFFF_FFFF, 2);
    send_request(64'h2000_0000_0000_0000, -9);
    send_request(64'h3FF8_0000_0000_0000, 7);
    send_request(64'hC008_0000_0000_0000, -5);

    for (k = 0; k < NumRandom; k++) begin
      maybe_idle(k < NumRandom - 150);
      if (k == NumRandom / 2) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_request(random_base(), random_exponent());
    end
    start <= 1'b0;

    // wait before checking pending so the last accepted request is already counted
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
